// ===== sv/tss_pkg.sv =====
// tss_pkg: shared types and constants for the tone scale sequencer
// used by tss_core, tone_scale_sequencer and tss_checker; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

  // sequencer phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_NOTE = 2'd1,
    PH_GAP  = 2'd2,
    PH_WAIT = 2'd3
  } phase_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_NOTE_MS = 1'b0,
    REG_GAP_MS  = 1'b1
  } cfg_reg_t;

  localparam int unsigned CLK_HZ = 32'd6250000;

  // rounded pwm clock / note frequency, c4 up to c5
  localparam logic [15:0] TONE_PERIOD [8] = '{
    16'((CLK_HZ + 262 / 2) / 262),
    16'((CLK_HZ + 294 / 2) / 294),
    16'((CLK_HZ + 330 / 2) / 330),
    16'((CLK_HZ + 349 / 2) / 349),
    16'((CLK_HZ + 392 / 2) / 392),
    16'((CLK_HZ + 440 / 2) / 440),
    16'((CLK_HZ + 494 / 2) / 494),
    16'((CLK_HZ + 523 / 2) / 523)
  };

  localparam logic [15:0] RESET_PERIOD  = 16'd23854;
  localparam logic [15:0] NOTE_MS_RESET = 16'd350;
  localparam logic [15:0] GAP_MS_RESET  = 16'd70;
  localparam logic [15:0] CNT_MAX       = 16'hFFFF;

  localparam int IN_W  = 8;
  localparam int OUT_W = 40;

  typedef struct packed {
    logic        busy;
    logic [2:0]  note_number;
    logic [14:0] duty_count;
    logic [15:0] pwm_period;
  } tss_result_t;

endpackage

`default_nettype wire

// ===== sv/tone_scale_sequencer.sv =====
// tone_scale_sequencer: millisecond-tick scale player producing pwm period and duty
// latency: a result is registered and appears in the cycle after its tick is accepted
// throughput: one tick per cycle; a held result blocks input only while the sink stalls
// reset: synchronous active-low; sequencer idle, switch seen as released,
//   period 23854, duty 0, note_ms 350, gap_ms 70, output register empty
// depends on tss_pkg and tss_core
`timescale 1ns / 1ps
`default_nettype none

module tone_scale_sequencer #(
  parameter int NOTES = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // tick input
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [tss_pkg::IN_W-1:0]  in_tdata,   // [0] start_level, [1] stop_pulse
  // result output
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [tss_pkg::OUT_W-1:0]      out_tdata,  // [15:0] pwm_period,
                                                     // [30:16] duty_count,
                                                     // [33:31] note_number, [34] busy_res
  // register writes
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [0:0]                cfg_index,
  input  wire logic [15:0]               cfg_data
);
  import tss_pkg::*;

  logic        in_acc;
  logic [15:0] note_ms_r;
  logic [15:0] gap_ms_r;
  logic        out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  tss_result_t res_nxt;

  // the output register can take a new result when empty or being drained
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      note_ms_r <= NOTE_MS_RESET;
      gap_ms_r  <= GAP_MS_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_NOTE_MS: note_ms_r <= cfg_data;
        REG_GAP_MS:  gap_ms_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer state advances by one tick per accepted transaction
  tss_core #(
    .NOTES (NOTES)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_acc),
    .level   (in_tdata[0]),
    .stop    (in_tdata[1]),
    .note_ms (note_ms_r),
    .gap_ms  (gap_ms_r),
    .res_nxt (res_nxt)
  );

  // output register: valid flag under reset, payload loaded on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= OUT_W'(res_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== sv/tss_core.sv =====
// tss_core: per-tick sequencer state and next-state logic
// depends on tss_pkg (phase type, tone table, result struct)
`timescale 1ns / 1ps
`default_nettype none

module tss_core #(
  parameter int NOTES = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step_en,
  input  wire logic                 level,
  input  wire logic                 stop,
  input  wire logic [15:0]          note_ms,
  input  wire logic [15:0]          gap_ms,
  output tss_pkg::tss_result_t      res_nxt
);
  import tss_pkg::*;

  localparam int PW = (NOTES > 1) ? $clog2(NOTES) : 1;
  localparam logic [PW-1:0] LAST_POS = PW'(NOTES - 1);

  phase_t       phase_r, phase_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [15:0]  cnt_r, cnt_nxt;
  logic         last_r, last_nxt;
  logic         stop_flag_r, stop_flag_nxt;
  logic [15:0]  period_r, period_nxt;
  logic [14:0]  duty_r, duty_nxt;

  logic [15:0]  note_len;
  logic [PW-1:0] pos_inc;
  logic [3:0]   inc_ext;
  logic [3:0]   pos_ext;

  assign note_len = (note_ms == 16'd0) ? 16'd1 : note_ms;
  assign pos_inc  = pos_r + 1'b1;
  assign inc_ext  = 4'(pos_inc);
  assign pos_ext  = 4'(pos_nxt);

  // next state
  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    stop_flag_nxt = stop_flag_r;
    period_nxt    = period_r;
    duty_nxt      = duty_r;
    last_nxt      = level;

    case (phase_r)
      PH_IDLE: begin
        // released-to-pressed edge starts note 0
        if (last_r && !level) begin
          stop_flag_nxt = 1'b0;
          pos_nxt       = '0;
          period_nxt    = TONE_PERIOD[0];
          duty_nxt      = TONE_PERIOD[0][15:1];
          phase_nxt     = PH_NOTE;
          cnt_nxt       = '0;
        end
      end
      PH_NOTE, PH_GAP: begin
        if (phase_nxt == PH_NOTE && cnt_nxt >= note_len) begin
          duty_nxt  = '0;
          phase_nxt = PH_GAP;
          cnt_nxt   = '0;
        end
        // zero gap falls straight through to the next note
        if (phase_nxt == PH_GAP && cnt_nxt >= gap_ms) begin
          if (pos_r == LAST_POS) begin
            duty_nxt  = '0;
            phase_nxt = PH_WAIT;
            cnt_nxt   = '0;
          end else begin
            pos_nxt    = pos_inc;
            period_nxt = TONE_PERIOD[inc_ext[2:0]];
            duty_nxt   = TONE_PERIOD[inc_ext[2:0]][15:1];
            phase_nxt  = PH_NOTE;
            cnt_nxt    = '0;
          end
        end
      end
      default: begin
      end
    endcase

    if ((phase_nxt == PH_NOTE || phase_nxt == PH_GAP) && cnt_nxt != CNT_MAX) begin
      cnt_nxt = cnt_nxt + 16'd1;
    end

    if (stop) begin
      stop_flag_nxt = 1'b1;
      duty_nxt      = '0;
      if (phase_nxt == PH_NOTE || phase_nxt == PH_GAP) begin
        phase_nxt = PH_WAIT;
        cnt_nxt   = '0;
      end
    end

    if (phase_nxt == PH_WAIT && level) begin
      phase_nxt = PH_IDLE;
    end
  end

  // result of this tick
  always_comb begin
    res_nxt.pwm_period  = period_nxt;
    res_nxt.duty_count  = duty_nxt;
    res_nxt.note_number = pos_ext[2:0];
    res_nxt.busy        = (phase_nxt == PH_NOTE || phase_nxt == PH_GAP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      pos_r       <= '0;
      cnt_r       <= '0;
      last_r      <= 1'b1;
      stop_flag_r <= 1'b0;
      period_r    <= RESET_PERIOD;
      duty_r      <= '0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      stop_flag_r <= stop_flag_nxt;
      period_r    <= period_nxt;
      duty_r      <= duty_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/tss_checker.sv =====
// tss_checker: port-level assertions for tone_scale_sequencer, with bind
// depends on tss_pkg and the top-level port list
`timescale 1ns / 1ps
`default_nettype none

module tss_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_tvalid,
  input wire logic                      in_tready,
  input wire logic [tss_pkg::IN_W-1:0]  in_tdata,
  input wire logic                      out_tvalid,
  input wire logic                      out_tready,
  input wire logic [tss_pkg::OUT_W-1:0] out_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a sounding output belongs to a running scale
  a_duty_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[30:16] != 15'd0 |-> out_tdata[34])
    else $error("duty nonzero while not busy");

  // a sounding note uses half its period as duty
  a_duty_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[30:16] != 15'd0 |-> out_tdata[30:16] == out_tdata[15:1])
    else $error("duty is not half the period");

  // a stop silences and ends the run in the result of that tick
  a_stop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[1]
      |=> out_tvalid && out_tdata[30:16] == 15'd0 && !out_tdata[34])
    else $error("stop did not silence the output");

endmodule

bind tone_scale_sequencer tss_checker u_tss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== tb/sv/tb_tone_scale_sequencer.sv =====
// tb_tone_scale_sequencer: self-checking bench for the tone scale sequencer, with a
// tick-level model of the scale run, directed corner tests and random press sequences
// depends on tss_pkg and tone_scale_sequencer
`timescale 1ns / 1ps

module tb_tone_scale_sequencer;
  import tss_pkg::*;

  localparam int          NOTES      = 8;
  localparam int unsigned PWM_CLK_HZ = 6250000;
  localparam int unsigned SCALE_HZ [8] = '{262, 294, 330, 349, 392, 440, 494, 523};
  localparam int          PHASE_TICKS = 160;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;   // [0] start_level, [1] stop_pulse
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;         // [15:0] period, [30:16] duty, [33:31] note, [34] busy
  logic             cfg_valid  = 1'b0;
  logic             cfg_ready;
  logic [0:0]       cfg_index  = REG_NOTE_MS;
  logic [15:0]      cfg_data   = '0;

  tone_scale_sequencer #(.NOTES(NOTES)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // sequencer model state
  phase_t      seq_phase;
  logic [2:0]  seq_note;
  logic [15:0] seq_ms;
  bit          seq_last_level;
  bit          seq_stop_flag;
  logic [15:0] seq_period;
  logic [14:0] seq_duty;
  logic [15:0] note_ms_q;
  logic [15:0] gap_ms_q;

  tss_result_t pwm_expect_q [$];
  int          fail_count  = 0;

  // source burst control and sink stall control
  int          burst_left  = 0;
  int          src_gap_max = 0;
  int          sink_hold   = 0;
  logic [15:0] sink_pattern = 16'hFFFF;

  function automatic logic [15:0] tone_period(int idx);
    int unsigned hz;
    hz = SCALE_HZ[idx % 8];
    return 16'((PWM_CLK_HZ + hz / 2) / hz);
  endfunction

  function automatic void start_note(int idx);
    seq_note   = 3'(idx);
    seq_period = tone_period(idx);
    seq_duty   = seq_period[15:1];
    seq_phase  = PH_NOTE;
    seq_ms     = '0;
  endfunction

  // one millisecond tick of the scale player, returns the pwm words after it
  function automatic tss_result_t sequence_tick(bit level, bit stop);
    logic [16:0] note_len;
    tss_result_t r;
    note_len = (note_ms_q == 16'd0) ? 17'd1 : {1'b0, note_ms_q};
    if (seq_phase == PH_IDLE) begin
      if (seq_last_level && !level) begin
        seq_stop_flag = 1'b0;
        start_note(0);
      end
    end else if (seq_phase == PH_NOTE || seq_phase == PH_GAP) begin
      if (seq_phase == PH_NOTE && {1'b0, seq_ms} >= note_len) begin
        seq_duty  = '0;
        seq_phase = PH_GAP;
        seq_ms    = '0;
      end
      if (seq_phase == PH_GAP && seq_ms >= gap_ms_q) begin
        if (int'(seq_note) + 1 >= NOTES) begin
          seq_duty  = '0;
          seq_phase = PH_WAIT;
          seq_ms    = '0;
        end else begin
          start_note(int'(seq_note) + 1);
        end
      end
    end
    // count spent ticks, saturating
    if ((seq_phase == PH_NOTE || seq_phase == PH_GAP) && seq_ms != 16'hFFFF) begin
      seq_ms = seq_ms + 16'd1;
    end
    if (stop) begin
      seq_stop_flag = 1'b1;
      seq_duty      = '0;
      if (seq_phase == PH_NOTE || seq_phase == PH_GAP) begin
        seq_phase = PH_WAIT;
        seq_ms    = '0;
      end
    end
    if (seq_phase == PH_WAIT && level) begin
      seq_phase = PH_IDLE;
    end
    seq_last_level = level;
    r.pwm_period  = seq_period;
    r.duty_count  = seq_duty;
    r.note_number = seq_note;
    r.busy        = (seq_phase == PH_NOTE || seq_phase == PH_GAP);
    return r;
  endfunction

  // sink ready: long hold-off when requested, otherwise a rotating pattern
  initial begin : sink_drive
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        out_tready <= 1'b0;
        sink_hold--;
      end else begin
        out_tready   <= sink_pattern[0];
        sink_pattern = {sink_pattern[0], sink_pattern[15:1]};
      end
    end
  end

  task automatic compare_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, got_v);
      fail_count++;
    end
  endtask

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin : result_check
    tss_result_t exp_r;
    tss_result_t got_r;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got_r = tss_result_t'(out_tdata[34:0]);
      if (pwm_expect_q.size() == 0) begin
        $display("%0t: result with none expected, expected none actual %h", $time, got_r);
        fail_count++;
      end else begin
        exp_r = pwm_expect_q.pop_front();
        compare_field("pwm_period", exp_r.pwm_period, got_r.pwm_period);
        compare_field("duty_count", exp_r.duty_count, got_r.duty_count);
        compare_field("note_number", exp_r.note_number, got_r.note_number);
        compare_field("busy_res", exp_r.busy, got_r.busy);
      end
    end
  end

  task automatic send_tick(input bit level, input bit stop);
    in_tdata  <= {6'b0, stop, level};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    pwm_expect_q.push_back(sequence_tick(level, stop));
  endtask

  task automatic source_gap(input int n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // send in bursts with random gaps between them
  task automatic stream_tick(input bit level, input bit stop);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (src_gap_max > 0) begin
        source_gap($urandom_range(0, src_gap_max));
      end
    end
    burst_left--;
    send_tick(level, stop);
  endtask

  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pwm_expect_q.size() != 0);
  endtask

  task automatic set_timing(input logic [15:0] note_len, input logic [15:0] gap_len);
    wait_results_done();
    repeat (2) @(posedge clk);   // let the output register settle
    cfg_valid <= 1'b1;
    cfg_index <= REG_NOTE_MS;
    cfg_data  <= note_len;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    note_ms_q = note_len;
    cfg_index <= REG_GAP_MS;
    cfg_data  <= gap_len;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    gap_ms_q  = gap_len;
    cfg_valid <= 1'b0;
  endtask

  // reset timing: idle outputs, stop while idle, start and stop during a note
  task automatic test_reset_defaults();
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);   // abort, switch still pressed
    send_tick(1'b1, 1'b0);
  endtask

  // one-tick notes with no gap; release during the run, then stop in the start tick
  task automatic test_zero_gap();
    set_timing(16'd1, 16'd0);
    send_tick(1'b0, 1'b0);
    repeat (8) send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
  endtask

  // zero note length plays one-tick notes; run to the end, stop while waiting
  task automatic test_zero_note_length();
    set_timing(16'd0, 16'd1);
    repeat (17) send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
  endtask

  task automatic test_register_extremes();
    set_timing(16'hFFFF, 16'hFFFF);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    set_timing(16'd1, 16'hFFFF);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
  endtask

  // random presses and releases, mostly long enough for whole runs
  task automatic random_press_phase(input int n_ticks, input bit noisy);
    bit level;
    bit stop;
    int hold;
    int run_ticks;
    level = 1'b1;
    hold  = 0;
    run_ticks = NOTES * ((note_ms_q == 0 ? 1 : int'(note_ms_q)) + int'(gap_ms_q));
    repeat (n_ticks) begin
      if (noisy) begin
        level = 1'($urandom_range(0, 1));
      end else begin
        if (hold == 0) begin
          level = !level;
          hold  = level ? $urandom_range(1, 4) : $urandom_range(1, run_ticks + 8);
        end
        hold--;
      end
      stop = ($urandom_range(0, 99) < 3);
      stream_tick(level, stop);
    end
  endtask

  task automatic test_random_runs();
    int p;
    for (p = 0; p < 8; p++) begin
      if (p == 3) begin
        set_timing(16'($urandom_range(20, 40)), 16'($urandom_range(0, 6)));
      end else if (p == 5) begin
        set_timing(16'd0, 16'($urandom_range(0, 3)));
      end else begin
        set_timing(16'($urandom_range(1, 8)), 16'($urandom_range(0, 5)));
      end
      // some phases run without any idling on either side
      src_gap_max  = (p % 3 == 0) ? 0 : $urandom_range(1, 6);
      sink_pattern = (p % 3 == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
      random_press_phase(PHASE_TICKS, (p == 6));
    end
  endtask

  // sink holds off long enough for the block to fill and stall its input
  task automatic test_output_stall();
    set_timing(16'd3, 16'd2);
    src_gap_max  = 0;
    sink_pattern = 16'hFFFF;
    sink_hold    = 120;
    random_press_phase(60, 1'b0);
    wait_results_done();
  endtask

  initial begin
    seq_phase      = PH_IDLE;
    seq_note       = '0;
    seq_ms         = '0;
    seq_last_level = 1'b1;
    seq_stop_flag  = 1'b0;
    seq_period     = 16'd23854;
    seq_duty       = '0;
    note_ms_q      = 16'd350;
    gap_ms_q       = 16'd70;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_zero_gap();
    test_zero_note_length();
    test_register_extremes();
    test_output_stall();
    test_random_runs();
    wait_results_done();
    repeat (4) @(posedge clk);   // catch any stray result
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : run_limit
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
